// ===== rtl/ppd_pkg.sv =====
package ppd_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 6;

    localparam int GUARD_BITS = 20;
    localparam int TABLE_LEN  = 24;
    localparam int RUN_STEPS  = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    // step vector: Q2.14, quotient magnitude up to 1.0
    localparam int STEP_W = 16;
    localparam int Q_BITS = 15;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int MAG_W  = COORD_WIDTH;
    localparam int NUM_W  = MAG_W + Q_BITS + 1;
    localparam int DIV_W  = MAG_W + 2;
    localparam int CORD_W = DIFF_W + GUARD_BITS + 3;
    localparam int Z_W    = 27;
    localparam int HEAD_W = 9 + ANGLE_FRAC_BITS;
    localparam int NSTG   = (RUN_STEPS > Q_BITS) ? RUN_STEPS : Q_BITS;

    localparam logic signed [Z_W-1:0] DEG90  = Z_W'(90 * 65536);
    localparam logic signed [Z_W-1:0] DEG180 = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] DEG360 = Z_W'(360 * 65536);
    localparam logic [HEAD_W-1:0]     HEAD_FULL = HEAD_W'(360 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
    } t_in;

    typedef struct packed {
        logic signed [STEP_W-1:0] step_x;
        logic signed [STEP_W-1:0] step_y;
        logic [HEAD_W-1:0]        heading;
    } t_out;

    // one word in flight: rotation state plus two restoring dividers
    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [Z_W-1:0]    z;
        logic [DIV_W-1:0]         rx;
        logic [DIV_W-1:0]         ry;
        logic [Q_BITS-1:0]        nlox;
        logic [Q_BITS-1:0]        nloy;
        logic [Q_BITS-1:0]        qx;
        logic [Q_BITS-1:0]        qy;
        logic [MAG_W-1:0]         m;
        logic                     neg_x;
        logic                     neg_y;
        logic                     zero;
    } t_work;

    // atan(2^-i) in degrees, Q.16
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = Z_W'(2949120);
            1:  v = Z_W'(1740967);
            2:  v = Z_W'(919879);
            3:  v = Z_W'(466945);
            4:  v = Z_W'(234379);
            5:  v = Z_W'(117304);
            6:  v = Z_W'(58666);
            7:  v = Z_W'(29335);
            8:  v = Z_W'(14668);
            9:  v = Z_W'(7334);
            10: v = Z_W'(3667);
            11: v = Z_W'(1833);
            12: v = Z_W'(917);
            13: v = Z_W'(458);
            14: v = Z_W'(229);
            15: v = Z_W'(115);
            16: v = Z_W'(57);
            17: v = Z_W'(29);
            18: v = Z_W'(14);
            19: v = Z_W'(7);
            20: v = Z_W'(4);
            21: v = Z_W'(2);
            22: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ppd_front.sv =====
module ppd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ppd_pkg::t_in   i_data,
    output logic           o_ready,
    output logic           o_valid,
    output ppd_pkg::t_work o_work,
    input  logic           i_dn_ready
);
    import ppd_pkg::*;

    logic signed [DIFF_W-1:0] dx, dy, xd, yd;
    logic [MAG_W-1:0]         ax, ay, m;
    logic [NUM_W-1:0]         numx, numy;
    t_work                    n_work;
    t_work                    r_work;
    logic                     r_vld;

    // differences, magnitudes, divider setup and half-plane fold
    always_comb begin
        dx = DIFF_W'(i_data.first_x) - DIFF_W'(i_data.second_x);
        dy = DIFF_W'(i_data.first_y) - DIFF_W'(i_data.second_y);
        ax = (dx < 0) ? MAG_W'(-dx) : MAG_W'(dx);
        ay = (dy < 0) ? MAG_W'(-dy) : MAG_W'(dy);
        m  = (ax > ay) ? ax : ay;
        numx = {1'b0, ax, {Q_BITS{1'b0}}} + NUM_W'(m);
        numy = {1'b0, ay, {Q_BITS{1'b0}}} + NUM_W'(m);
        xd = (dx < 0) ? -dx : dx;
        yd = (dx < 0) ? -dy : dy;
        n_work       = '0;
        n_work.x     = CORD_W'(xd) <<< GUARD_BITS;
        n_work.y     = CORD_W'(yd) <<< GUARD_BITS;
        n_work.z     = (dx < 0) ? DEG180 : '0;
        n_work.rx    = DIV_W'(numx >> Q_BITS);
        n_work.ry    = DIV_W'(numy >> Q_BITS);
        n_work.nlox  = numx[Q_BITS-1:0];
        n_work.nloy  = numy[Q_BITS-1:0];
        n_work.m     = m;
        n_work.neg_x = (dx < 0);
        n_work.neg_y = (dy < 0);
        n_work.zero  = (m == '0);
    end

    assign o_ready = !r_vld || i_dn_ready;

    // advance the entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_vld;
    assign o_work  = r_work;

endmodule

// ===== rtl/ppd_iter.sv =====
module ppd_iter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ppd_pkg::t_work i_work,
    output logic           o_ready,
    output logic           o_valid,
    output ppd_pkg::t_work o_work,
    input  logic           i_dn_ready
);
    import ppd_pkg::*;

    t_work          src   [NSTG];
    t_work          rot   [NSTG];
    t_work          n_st  [NSTG];
    t_work          r_st  [NSTG];
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] vin;

    assign rdy[NSTG] = i_dn_ready;

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        localparam logic signed [Z_W-1:0] ANG = atan_q16(k);

        if (k == 0) begin : g_first
            assign src[k] = i_work;
            assign vin[k] = i_valid;
        end else begin : g_next
            assign src[k] = r_st[k-1];
            assign vin[k] = r_vld[k-1];
        end

        assign rdy[k] = !r_vld[k] || rdy[k+1];

        // one rotation step toward the x axis
        if (k < RUN_STEPS) begin : g_rot
            always_comb begin
                rot[k] = src[k];
                if (src[k].y > 0) begin
                    rot[k].x = src[k].x + (src[k].y >>> k);
                    rot[k].y = src[k].y - (src[k].x >>> k);
                    rot[k].z = src[k].z + ANG;
                end else begin
                    rot[k].x = src[k].x - (src[k].y >>> k);
                    rot[k].y = src[k].y + (src[k].x >>> k);
                    rot[k].z = src[k].z - ANG;
                end
            end
        end else begin : g_nrot
            assign rot[k] = src[k];
        end

        // one quotient bit for each step component
        if (k < Q_BITS) begin : g_div
            logic [DIV_W-1:0] tx, ty, dv;
            always_comb begin
                n_st[k] = rot[k];
                dv = {1'b0, src[k].m, 1'b0};
                tx = {src[k].rx[DIV_W-2:0], src[k].nlox[Q_BITS-1-k]};
                ty = {src[k].ry[DIV_W-2:0], src[k].nloy[Q_BITS-1-k]};
                if (tx >= dv) begin
                    n_st[k].rx = tx - dv;
                    n_st[k].qx[Q_BITS-1-k] = 1'b1;
                end else begin
                    n_st[k].rx = tx;
                    n_st[k].qx[Q_BITS-1-k] = 1'b0;
                end
                if (ty >= dv) begin
                    n_st[k].ry = ty - dv;
                    n_st[k].qy[Q_BITS-1-k] = 1'b1;
                end else begin
                    n_st[k].ry = ty;
                    n_st[k].qy[Q_BITS-1-k] = 1'b0;
                end
            end
        end else begin : g_ndiv
            assign n_st[k] = rot[k];
        end

        // advance or hold this stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_vld[k] <= vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k] && vin[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_work  = r_st[NSTG-1];

endmodule

// ===== rtl/ppd_back.sv =====
module ppd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ppd_pkg::t_work i_work,
    output logic           o_ready,
    output logic           o_valid,
    output ppd_pkg::t_out  o_data,
    input  logic           i_stall
);
    import ppd_pkg::*;

    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] RND = Z_W'(1 << (15 - ANGLE_FRAC_BITS));

    logic signed [Z_W-1:0] ze, h0, hw, hr;
    logic [HEAD_W-1:0]     units;
    t_out                  n_out;
    t_out                  r_out;
    logic                  r_vld;

    // heading wrap and rounding, sign of the step vector
    always_comb begin
        ze = i_work.zero ? '0 : i_work.z;
        h0 = ze - DEG90;
        if (h0 < 0) begin
            hw = h0 + DEG360;
        end else if (h0 >= DEG360) begin
            hw = h0 - DEG360;
        end else begin
            hw = h0;
        end
        hr    = hw + RND;
        units = HEAD_W'(hr >>> SH);
        if (units >= HEAD_FULL) begin
            units = units - HEAD_FULL;
        end
        n_out.heading = units;
        if (i_work.zero) begin
            n_out.step_x = '0;
            n_out.step_y = '0;
        end else begin
            n_out.step_x = i_work.neg_x ? -STEP_W'(i_work.qx) : STEP_W'(i_work.qx);
            n_out.step_y = i_work.neg_y ? -STEP_W'(i_work.qy) : STEP_W'(i_work.qy);
        end
    end

    assign o_ready = !r_vld || !i_stall;

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_out;

endmodule

// ===== rtl/point_pair_direction_core.sv =====
// Channel   Valid     Stall     Word
// input     i_valid   o_stall   i_data  (t_in: two points)
// output    o_valid   i_stall   o_data  (t_out: step vector, heading)
//
// Stages: one entry stage, one stage per rotation step or quotient bit,
// and one output stage.
// One word per cycle is taken while the output is not stalled.
// Reset is synchronous, active low, and clears only the stage valid bits.
// A stall holds the output word; empty stages ahead of it still fill.
module point_pair_direction_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ppd_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output ppd_pkg::t_out o_data,
    input  logic          i_stall
);
    import ppd_pkg::*;

    t_work f_work, it_work;
    logic  f_valid, f_ready, it_valid, it_ready, b_ready;

    ppd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_ready    (f_ready),
        .o_valid    (f_valid),
        .o_work     (f_work),
        .i_dn_ready (it_ready)
    );

    ppd_iter u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_valid),
        .i_work     (f_work),
        .o_ready    (it_ready),
        .o_valid    (it_valid),
        .o_work     (it_work),
        .i_dn_ready (b_ready)
    );

    ppd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (it_valid),
        .i_work  (it_work),
        .o_ready (b_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    assign o_stall = !f_ready;

endmodule

// ===== rtl/ppd_checker.sv =====
module ppd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input ppd_pkg::t_out o_data,
    input logic          i_stall
);
    import ppd_pkg::*;

    // a stalled word stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("output word changed under stall");

    // heading wraps below a full turn
    a_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.heading < HEAD_FULL)
        else $error("heading out of range");

    // step components never exceed one in magnitude
    a_step_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.step_x <= 16384 && o_data.step_x >= -16384))
        else $error("step_x out of range");

    a_step_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.step_y <= 16384 && o_data.step_y >= -16384))
        else $error("step_y out of range");

endmodule

bind point_pair_direction_core ppd_checker u_ppd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);
